/* sv/sorted_table_binary_search_core_macros.svh */
// assertion macros used by the checker file
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define STS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset cycles included
`define STS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sts_pkg.sv */
// shared types and constants for the sorted table search core
`timescale 1ns / 1ps

package sts_pkg;

  // fixed field widths
  localparam int SLOT_W  = 10;
  localparam int KEY_IN_W = 32;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;

  // item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // one search result
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

/* sv/sts_key_mem.sv */
// key table storage: one write port, one registered read port
`timescale 1ns / 1ps

module sts_key_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/sts_ctrl.sv */
// search sequencer: takes items, writes the table, runs the probe loop
`timescale 1ns / 1ps

module sts_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [sts_pkg::SLOT_W-1:0]  slot,
  input  logic [sts_pkg::KEY_IN_W-1:0] key_value,
  // entries taking part, already limited to the table depth
  input  logic [CNT_W-1:0]            count,
  // table ports
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [KEY_WIDTH-1:0]        wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [KEY_WIDTH-1:0]        rd_data,
  // finished result
  output logic                        res_valid,
  input  logic                        res_ready,
  output sts_pkg::result_t            res
);

  sts_pkg::state_t state, state_next;
  logic [CNT_W-1:0]     lower, lower_next;
  logic [CNT_W-1:0]     upper, upper_next;
  logic [ADDR_W-1:0]    probe, probe_next;
  logic [KEY_WIDTH-1:0] key, key_next;
  sts_pkg::result_t     result, result_next;

  logic [KEY_WIDTH-1:0] key_in;
  logic                 slot_ok;
  logic [ADDR_W-1:0]    start_mid;
  logic [CNT_W-1:0]     probe_ext;
  logic [CNT_W-1:0]     probe_inc;
  logic [CNT_W:0]       sum_lo;
  logic [CNT_W:0]       sum_hi;
  logic [ADDR_W-1:0]    mid_lo;
  logic [ADDR_W-1:0]    mid_hi;
  logic                 go_lo;
  logic                 go_hi;
  logic                 cmp_eq;
  logic                 cmp_lt;

  // input decode
  assign key_in    = KEY_WIDTH'(key_value);
  assign slot_ok   = 32'(slot) < 32'(TABLE_DEPTH);
  assign start_mid = ADDR_W'(count >> 1);

  // both candidate next probes, ready before the table data arrives
  assign probe_ext = CNT_W'(probe);
  assign probe_inc = probe_ext + CNT_W'(1);
  assign sum_lo    = {1'b0, lower} + {1'b0, probe_ext};
  assign sum_hi    = {1'b0, probe_inc} + {1'b0, upper};
  assign mid_lo    = ADDR_W'(sum_lo[CNT_W:1]);
  assign mid_hi    = ADDR_W'(sum_hi[CNT_W:1]);
  assign go_lo     = lower < probe_ext;
  assign go_hi     = probe_inc < upper;

  // key compare against the probed entry
  assign cmp_eq = key == rd_data;
  assign cmp_lt = key < rd_data;

  assign wr_addr = ADDR_W'(slot);
  assign wr_data = key_in;
  assign res     = result;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    lower  <= lower_next;
    upper  <= upper_next;
    probe  <= probe_next;
    key    <= key_next;
    result <= result_next;
  end

  // next state and outputs
  always_comb begin
    state_next  = state;
    lower_next  = lower;
    upper_next  = upper;
    probe_next  = probe;
    key_next    = key;
    result_next = result;
    in_ready    = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = probe;
    res_valid   = 1'b0;
    case (state)
      sts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == sts_pkg::MODE_WRITE) begin
            wr_en = slot_ok;
          end else begin
            lower_next = '0;
            upper_next = count;
            key_next   = key_in;
            if (count != '0) begin
              rd_en      = 1'b1;
              rd_addr    = start_mid;
              probe_next = start_mid;
              state_next = sts_pkg::ST_SEARCH;
            end else begin
              result_next = '0;
              state_next  = sts_pkg::ST_DONE;
            end
          end
        end
      end
      sts_pkg::ST_SEARCH: begin
        if (cmp_eq) begin
          result_next.found    = 1'b1;
          result_next.position = sts_pkg::POS_W'(probe);
          state_next           = sts_pkg::ST_DONE;
        end else if (cmp_lt) begin
          // sought key is below the probe
          upper_next = probe_ext;
          if (go_lo) begin
            rd_en      = 1'b1;
            rd_addr    = mid_lo;
            probe_next = mid_lo;
          end else begin
            result_next = '0;
            state_next  = sts_pkg::ST_DONE;
          end
        end else begin
          // sought key is above the probe
          lower_next = probe_inc;
          if (go_hi) begin
            rd_en      = 1'b1;
            rd_addr    = mid_hi;
            probe_next = mid_hi;
          end else begin
            result_next = '0;
            state_next  = sts_pkg::ST_DONE;
          end
        end
      end
      sts_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/sorted_table_binary_search_core.sv */
// a write is taken in idle and the sequencer stays there; in_ready stays high for the next item
// a search makes P probes, one table read per probe, and then loads its result register;
// P is at most floor(log2(TABLE_DEPTH)) + 1 (11 at 1024 entries)
// a search holds in_ready low until its result is taken; one item in work at a time
// rst clears the sequencer, out_valid and entry_count to 0
// the key table is not cleared; entries read before written are undefined
`timescale 1ns / 1ps

module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [sts_pkg::COUNT_W-1:0]  cfg_data,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [sts_pkg::SLOT_W-1:0]   slot,
  input  logic [sts_pkg::KEY_IN_W-1:0] key_value,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [sts_pkg::POS_W-1:0]    position
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic [sts_pkg::COUNT_W-1:0] entry_count;
  logic [CNT_W-1:0]            count_eff;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0]  wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0]  rd_data;

  logic                  res_valid;
  logic                  res_ready;
  sts_pkg::result_t      res;

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  // limit the count to the table depth
  assign count_eff = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entry_count);

  sts_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sts_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .slot      (slot),
    .key_value (key_value),
    .count     (count_eff),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found    <= res.found;
      position <= res.position;
    end
  end

endmodule

/* sv/sts_checker.sv */
// port-level checks for the sorted table search core, bound to the top level
`timescale 1ns / 1ps
`include "sorted_table_binary_search_core_macros.svh"

module sts_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      mode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      found,
  input logic [sts_pkg::POS_W-1:0] position
);

  // a waiting result holds until its transfer
  `STS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position), "result changed before transfer")

  // a miss always reports position zero
  `STS_ASSERT(a_miss_pos, out_valid && !found |-> position == '0, "miss with nonzero position")

  // a search keeps the input side busy for the next cycle
  `STS_ASSERT(a_search_busy, in_valid && in_ready && mode == sts_pkg::MODE_SEARCH |=> !in_ready, "search transfer left input ready")

  // reset empties the output register
  `STS_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind sorted_table_binary_search_core sts_checker u_sts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .position  (position)
);
